### rtl/sfcs_pkg.sv
// ----------------------------------------------------------------------------
// sfcs_pkg - shared types and constants of the SPI flash command sequencer
// Request and result payloads, configuration set, command descriptor and the
// table that spells out the byte frames of each command.
// ----------------------------------------------------------------------------
package sfcs_pkg;

    // Field widths and geometry
    localparam int ADDR_W       = 24;
    localparam int BYTE_W       = 8;
    localparam int ADDRESS_BITS = 24;
    localparam int SECTOR_BITS  = 12;

    localparam logic [ADDR_W-1:0] ADDR_MASK   = ADDR_W'((33'd1 << ADDRESS_BITS) - 33'd1);
    localparam logic [ADDR_W-1:0] SECTOR_MASK = ADDR_W'((25'd1 << SECTOR_BITS) - 25'd1);

    localparam logic [BYTE_W-1:0] DUMMY_BYTE = 8'hFF;
    localparam int                BUSY_BIT   = 0;

    // Command queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_OP_READ          = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_OP_WRITE_ENABLE  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_OP_WRITE_DISABLE = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_OP_SECTOR_ERASE  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_OP_AAI_PROGRAM   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_OP_READ_STATUS   = 3'd5;

    localparam logic [BYTE_W-1:0] RST_OP_READ          = 8'h03;
    localparam logic [BYTE_W-1:0] RST_OP_WRITE_ENABLE  = 8'h06;
    localparam logic [BYTE_W-1:0] RST_OP_WRITE_DISABLE = 8'h04;
    localparam logic [BYTE_W-1:0] RST_OP_SECTOR_ERASE  = 8'h20;
    localparam logic [BYTE_W-1:0] RST_OP_AAI_PROGRAM   = 8'hAD;
    localparam logic [BYTE_W-1:0] RST_OP_READ_STATUS   = 8'h05;

    // Request modes
    localparam logic [2:0] MODE_READ_OPEN   = 3'd0;
    localparam logic [2:0] MODE_READ_BYTE   = 3'd1;
    localparam logic [2:0] MODE_READ_CLOSE  = 3'd2;
    localparam logic [2:0] MODE_WRITE_OPEN  = 3'd3;
    localparam logic [2:0] MODE_WRITE_PAIR  = 3'd4;
    localparam logic [2:0] MODE_WRITE_CLOSE = 3'd5;
    localparam logic [2:0] MODE_STATUS      = 3'd6;

    typedef struct packed {
        logic [2:0]        mode;
        logic [ADDR_W-1:0] address;
        logic [BYTE_W-1:0] data_first;
        logic [BYTE_W-1:0] data_second;
        logic [BYTE_W-1:0] status_byte;
    } sfcs_in_t;

    typedef struct packed {
        logic [BYTE_W-1:0] tx_byte;
        logic              tx_valid;
        logic              frame_start;
        logic              frame_end;
        logic              capture_rx;
        logic              error;
        logic              last;
    } sfcs_out_t;

    typedef struct packed {
        logic [BYTE_W-1:0] op_read;
        logic [BYTE_W-1:0] op_write_enable;
        logic [BYTE_W-1:0] op_write_disable;
        logic [BYTE_W-1:0] op_sector_erase;
        logic [BYTE_W-1:0] op_aai_program;
        logic [BYTE_W-1:0] op_read_status;
    } cfg_t;

    // Protocol phase of the flash
    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_READING = 4'b0010,
        PH_BUSY    = 4'b0100,
        PH_WRITING = 4'b1000
    } phase_t;

    // What to do once the busy bit clears
    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_ERASED = 2'd1,
        ACT_PAIRED = 2'd2
    } action_t;

    // Command kinds handed from front to back
    typedef enum logic [3:0] {
        K_READ_OPEN   = 4'd0,
        K_READ_BYTE   = 4'd1,
        K_READ_CLOSE  = 4'd2,
        K_WRITE_OPEN  = 4'd3,
        K_PAIR        = 4'd4,
        K_WRITE_CLOSE = 4'd5,
        K_POLL        = 4'd6,
        K_WE_AFTER    = 4'd7,
        K_DONE        = 4'd8,
        K_ERROR       = 4'd9
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [ADDR_W-1:0] address;
        logic [BYTE_W-1:0] data_first;
        logic [BYTE_W-1:0] data_second;
        logic              first_pair;
    } desc_t;

    // Source of one result byte
    typedef enum logic [3:0] {
        SL_WD    = 4'd0,
        SL_RD    = 4'd1,
        SL_WE    = 4'd2,
        SL_SE    = 4'd3,
        SL_AAI   = 4'd4,
        SL_RS    = 4'd5,
        SL_AH    = 4'd6,
        SL_AM    = 4'd7,
        SL_AL    = 4'd8,
        SL_D1    = 4'd9,
        SL_D2    = 4'd10,
        SL_DUMMY = 4'd11,
        SL_EMPTY = 4'd12,
        SL_ERR   = 4'd13
    } slot_t;

    typedef struct packed {
        slot_t slot;
        logic  frame_start;
        logic  frame_end;
        logic  capture_rx;
        logic  last;
    } step_info_t;

    // Frame table: byte source and framing of each step of each command.
    // A pair that carries the address uses steps 0..7; one without it skips
    // the three address steps.
    function automatic step_info_t step_info(kind_t kind, logic [2:0] step);
        step_info_t info;
        info      = '0;
        info.slot = SL_EMPTY;
        unique case (kind)
            K_READ_OPEN: begin
                unique case (step)
                    3'd0: begin
                        info.slot = SL_WD; info.frame_start = 1'b1; info.frame_end = 1'b1;
                    end
                    3'd1: begin
                        info.slot = SL_RD; info.frame_start = 1'b1;
                    end
                    3'd2: info.slot = SL_AH;
                    3'd3: info.slot = SL_AM;
                    default: begin
                        info.slot = SL_AL; info.last = 1'b1;
                    end
                endcase
            end
            K_READ_BYTE: begin
                info.slot = SL_DUMMY; info.capture_rx = 1'b1; info.last = 1'b1;
            end
            K_READ_CLOSE: begin
                info.slot = SL_EMPTY; info.frame_end = 1'b1; info.last = 1'b1;
            end
            K_WRITE_OPEN: begin
                unique case (step)
                    3'd0: begin
                        info.slot = SL_WE; info.frame_start = 1'b1; info.frame_end = 1'b1;
                    end
                    3'd1: begin
                        info.slot = SL_SE; info.frame_start = 1'b1;
                    end
                    3'd2: info.slot = SL_AH;
                    3'd3: info.slot = SL_AM;
                    3'd4: begin
                        info.slot = SL_AL; info.frame_end = 1'b1;
                    end
                    3'd5: begin
                        info.slot = SL_RS; info.frame_start = 1'b1;
                    end
                    default: begin
                        info.slot = SL_DUMMY; info.frame_end = 1'b1;
                        info.capture_rx = 1'b1; info.last = 1'b1;
                    end
                endcase
            end
            K_PAIR: begin
                unique case (step)
                    3'd0: begin
                        info.slot = SL_AAI; info.frame_start = 1'b1;
                    end
                    3'd1: info.slot = SL_AH;
                    3'd2: info.slot = SL_AM;
                    3'd3: info.slot = SL_AL;
                    3'd4: info.slot = SL_D1;
                    3'd5: begin
                        info.slot = SL_D2; info.frame_end = 1'b1;
                    end
                    3'd6: begin
                        info.slot = SL_RS; info.frame_start = 1'b1;
                    end
                    default: begin
                        info.slot = SL_DUMMY; info.frame_end = 1'b1;
                        info.capture_rx = 1'b1; info.last = 1'b1;
                    end
                endcase
            end
            K_WRITE_CLOSE: begin
                info.slot = SL_WD; info.frame_start = 1'b1;
                info.frame_end = 1'b1; info.last = 1'b1;
            end
            K_POLL: begin
                if (step == 3'd0) begin
                    info.slot = SL_RS; info.frame_start = 1'b1;
                end else begin
                    info.slot = SL_DUMMY; info.frame_end = 1'b1;
                    info.capture_rx = 1'b1; info.last = 1'b1;
                end
            end
            K_WE_AFTER: begin
                info.slot = SL_WE; info.frame_start = 1'b1;
                info.frame_end = 1'b1; info.last = 1'b1;
            end
            K_DONE: begin
                info.slot = SL_EMPTY; info.last = 1'b1;
            end
            default: begin
                info.slot = SL_ERR; info.last = 1'b1;
            end
        endcase
        return info;
    endfunction

endpackage

### rtl/sfcs_front.sv
// ----------------------------------------------------------------------------
// sfcs_front - request classifier
// Tracks the flash protocol phase, checks each request against it and turns
// it into one command descriptor for the back end.
// ----------------------------------------------------------------------------
module sfcs_front import sfcs_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  sfcs_in_t s_data,
    input  logic     q_full,
    output logic     push,
    output desc_t    push_desc
);

    phase_t            phase_reg, phase_next;
    logic [ADDR_W-1:0] sector_reg, sector_next;
    logic              first_reg, first_next;
    action_t           action_reg, action_next;
    logic [ADDR_W-1:0] addr_masked;

    assign s_ready     = !q_full;
    assign push        = s_valid && !q_full;
    assign addr_masked = s_data.address & ADDR_MASK;

    // Classify the request and work out the next phase
    always_comb begin
        phase_next            = phase_reg;
        sector_next           = sector_reg;
        first_next            = first_reg;
        action_next           = action_reg;
        push_desc.kind        = K_ERROR;
        push_desc.address     = addr_masked;
        push_desc.data_first  = s_data.data_first;
        push_desc.data_second = s_data.data_second;
        push_desc.first_pair  = first_reg;
        priority if (s_data.mode == MODE_READ_OPEN && phase_reg == PH_IDLE) begin
            push_desc.kind = K_READ_OPEN;
            phase_next     = PH_READING;
        end else if (s_data.mode == MODE_READ_BYTE && phase_reg == PH_READING) begin
            push_desc.kind = K_READ_BYTE;
        end else if (s_data.mode == MODE_READ_CLOSE && phase_reg == PH_READING) begin
            push_desc.kind = K_READ_CLOSE;
            phase_next     = PH_IDLE;
        end else if (s_data.mode == MODE_WRITE_OPEN && phase_reg == PH_IDLE) begin
            sector_next       = addr_masked & ~SECTOR_MASK;
            push_desc.kind    = K_WRITE_OPEN;
            push_desc.address = addr_masked & ~SECTOR_MASK;
            first_next        = 1'b1;
            action_next       = ACT_ERASED;
            phase_next        = PH_BUSY;
        end else if (s_data.mode == MODE_WRITE_PAIR && phase_reg == PH_WRITING) begin
            push_desc.kind    = K_PAIR;
            push_desc.address = sector_reg;
            first_next        = 1'b0;
            action_next       = ACT_PAIRED;
            phase_next        = PH_BUSY;
        end else if (s_data.mode == MODE_WRITE_CLOSE && phase_reg == PH_WRITING) begin
            push_desc.kind = K_WRITE_CLOSE;
            first_next     = 1'b0;
            phase_next     = PH_IDLE;
        end else if (s_data.mode == MODE_STATUS && phase_reg == PH_BUSY) begin
            if (s_data.status_byte[BUSY_BIT]) begin
                push_desc.kind = K_POLL;
            end else begin
                push_desc.kind = (action_reg == ACT_ERASED) ? K_WE_AFTER : K_DONE;
                action_next    = ACT_NONE;
                phase_next     = PH_WRITING;
            end
        end else begin
            push_desc.kind = K_ERROR;
        end
    end

    // Commit the phase on each accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            sector_reg <= '0;
            first_reg  <= 1'b0;
            action_reg <= ACT_NONE;
        end else if (push) begin
            phase_reg  <= phase_next;
            sector_reg <= sector_next;
            first_reg  <= first_next;
            action_reg <= action_next;
        end
    end

endmodule

### rtl/sfcs_queue.sv
// ----------------------------------------------------------------------------
// sfcs_queue - command descriptor queue
// Short first-in first-out buffer between the classifier and the frame
// generator.
// ----------------------------------------------------------------------------
module sfcs_queue import sfcs_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  desc_t push_desc,
    output logic  full,
    input  logic  pop,
    output logic  q_valid,
    output desc_t q_desc
);

    desc_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_desc  = entry_reg[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    // Store the pushed descriptor
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/sfcs_back.sv
// ----------------------------------------------------------------------------
// sfcs_back - frame generator
// Takes one command descriptor at a time and emits its result bytes, one per
// cycle while the consumer keeps up, through a registered output stage.
// ----------------------------------------------------------------------------
module sfcs_back import sfcs_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      q_valid,
    input  desc_t     q_desc,
    output logic      pop,
    output logic      m_valid,
    input  logic      m_ready,
    output sfcs_out_t m_data
);

    desc_t      desc_reg;
    logic       act_reg;
    logic [2:0] step_reg;
    logic       m_valid_reg;
    sfcs_out_t  m_data_reg;

    logic       out_free;
    logic       emit;
    logic       done;
    logic [2:0] eff_step;
    step_info_t info;
    sfcs_out_t  result;

    assign out_free = !m_valid_reg || m_ready;
    assign emit     = act_reg && out_free;

    // Skip the address steps of a pair that follows the first one
    assign eff_step = (desc_reg.kind == K_PAIR && !desc_reg.first_pair && step_reg != 3'd0)
                      ? step_reg + 3'd3 : step_reg;
    assign info     = step_info(desc_reg.kind, eff_step);
    assign done     = emit && info.last;
    assign pop      = q_valid && (!act_reg || done);

    // Pick the byte for the current step
    always_comb begin
        result             = '0;
        result.frame_start = info.frame_start;
        result.frame_end   = info.frame_end;
        result.capture_rx  = info.capture_rx;
        result.last        = info.last;
        result.tx_valid    = 1'b1;
        unique case (info.slot)
            SL_WD:    result.tx_byte = cfg.op_write_disable;
            SL_RD:    result.tx_byte = cfg.op_read;
            SL_WE:    result.tx_byte = cfg.op_write_enable;
            SL_SE:    result.tx_byte = cfg.op_sector_erase;
            SL_AAI:   result.tx_byte = cfg.op_aai_program;
            SL_RS:    result.tx_byte = cfg.op_read_status;
            SL_AH:    result.tx_byte = desc_reg.address[23:16];
            SL_AM:    result.tx_byte = desc_reg.address[15:8];
            SL_AL:    result.tx_byte = desc_reg.address[7:0];
            SL_D1:    result.tx_byte = desc_reg.data_first;
            SL_D2:    result.tx_byte = desc_reg.data_second;
            SL_DUMMY: result.tx_byte = DUMMY_BYTE;
            SL_ERR: begin
                result.tx_valid = 1'b0;
                result.error    = 1'b1;
            end
            default:  result.tx_valid = 1'b0;
        endcase
    end

    // Load the next descriptor, or step through the current one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg  <= 1'b0;
            step_reg <= '0;
        end else if (pop) begin
            act_reg  <= 1'b1;
            step_reg <= '0;
        end else if (done) begin
            act_reg <= 1'b0;
        end else if (emit) begin
            step_reg <= step_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            desc_reg <= q_desc;
        end
    end

    // Hold the result until the consumer takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### rtl/spi_flash_command_sequencer_top.sv
// ----------------------------------------------------------------------------
// spi_flash_command_sequencer_top - SPI NOR flash command sequencer
// Turns host requests into the byte frames that drive a serial NOR flash,
// with opcode registers on an APB-style port.
//
//   channel   direction  handshake            payload
//   s_        in         s_valid / s_ready    sfcs_in_t  (one request)
//   m_        out        m_valid / m_ready    sfcs_out_t (one frame byte)
//   apb       in/out     psel/penable/pready  opcode registers
//
// Each request yields 1 to 8 result bytes, one per clock while m_ready is
// high; sustained rate is one result byte per cycle, paced by the frame
// generator stepping through its frame table. An accepted request enters
// the command queue, then the frame generator, then its output register.
// A four-entry command queue lets requests be taken while bytes still drain.
// Reset (aresetn low, synchronous) returns to the idle phase, empties the
// queue and restores the opcode defaults; m_ready low holds the output.
// ----------------------------------------------------------------------------
module spi_flash_command_sequencer_top import sfcs_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sfcs_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sfcs_out_t             m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t                 cfg_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 reg_wr;
    logic                 push;
    desc_t                push_desc;
    logic                 q_full;
    logic                 q_valid;
    desc_t                q_desc;
    logic                 pop;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign reg_wr  = psel && penable && pwrite;

    // Write opcode registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.op_read          <= RST_OP_READ;
            cfg_reg.op_write_enable  <= RST_OP_WRITE_ENABLE;
            cfg_reg.op_write_disable <= RST_OP_WRITE_DISABLE;
            cfg_reg.op_sector_erase  <= RST_OP_SECTOR_ERASE;
            cfg_reg.op_aai_program   <= RST_OP_AAI_PROGRAM;
            cfg_reg.op_read_status   <= RST_OP_READ_STATUS;
        end else if (reg_wr) begin
            unique case (reg_idx)
                REG_OP_READ:          cfg_reg.op_read          <= pwdata[7:0];
                REG_OP_WRITE_ENABLE:  cfg_reg.op_write_enable  <= pwdata[7:0];
                REG_OP_WRITE_DISABLE: cfg_reg.op_write_disable <= pwdata[7:0];
                REG_OP_SECTOR_ERASE:  cfg_reg.op_sector_erase  <= pwdata[7:0];
                REG_OP_AAI_PROGRAM:   cfg_reg.op_aai_program   <= pwdata[7:0];
                REG_OP_READ_STATUS:   cfg_reg.op_read_status   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read back opcode registers
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_OP_READ:          prdata[7:0] = cfg_reg.op_read;
            REG_OP_WRITE_ENABLE:  prdata[7:0] = cfg_reg.op_write_enable;
            REG_OP_WRITE_DISABLE: prdata[7:0] = cfg_reg.op_write_disable;
            REG_OP_SECTOR_ERASE:  prdata[7:0] = cfg_reg.op_sector_erase;
            REG_OP_AAI_PROGRAM:   prdata[7:0] = cfg_reg.op_aai_program;
            REG_OP_READ_STATUS:   prdata[7:0] = cfg_reg.op_read_status;
            default:              prdata      = '0;
        endcase
    end

    sfcs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_full    (q_full),
        .push      (push),
        .push_desc (push_desc)
    );

    sfcs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_desc    (q_desc)
    );

    sfcs_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_desc  (q_desc),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`ifndef SYNTHESIS
    // No result may leave the cycle after reset
    a_reset_quiet: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid straight after reset");

    // A refused request yields a lone, unsent, final result
    a_error_lone: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.error) |->
            (m_data.last && !m_data.tx_valid && !m_data.frame_start && !m_data.frame_end))
        else $error("error result carries frame fields");

    // Captured bytes are always clocked by a dummy byte that opens no frame
    a_capture_dummy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.capture_rx) |->
            (m_data.tx_valid && m_data.tx_byte == DUMMY_BYTE && !m_data.frame_start))
        else $error("capture without dummy byte");

    // A descriptor is only taken when the queue has one
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_valid)
        else $error("pop from empty queue");
`endif

endmodule

### tb/sv/tb_spi_flash_command_sequencer_top.sv
// ----------------------------------------------------------------------------
// tb_spi_flash_command_sequencer_top - self-checking bench of the SPI flash
// command sequencer
// Feeds read and write sessions, status replies and out-of-phase requests
// through the request channel. A behavioural predictor of the flash protocol
// works out the frame bytes of each accepted request. A monitor compares
// every result byte, field by field, with the oldest expected byte. Opcode
// registers are reprogrammed over the APB-style port between phases, while
// both sides idle and stall at different rates.
// ----------------------------------------------------------------------------
module tb_spi_flash_command_sequencer_top;
    import sfcs_pkg::*;

    localparam logic [2:0] MODE_UNDEFINED = 3'd7;
    localparam int         CLK_PERIOD     = 20;
    localparam int         TIMEOUT_CYCLES = 200_000;
    localparam int         MAX_REPORTS    = 40;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    sfcs_in_t              s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    sfcs_out_t             m_data;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Requests waiting to be driven and frame bytes waiting to come out
    sfcs_in_t  pending_reqs[$];
    sfcs_out_t expected_bytes[$];
    sfcs_in_t  next_req;
    logic      req_taken = 1'b0;

    int send_idle_pct  = 22;
    int recv_stall_pct = 79;
    int failures       = 0;
    int reqs_queued    = 0;

    // Predictor state: flash protocol and opcode set
    phase_t            flash_phase = PH_IDLE;
    logic [ADDR_W-1:0] sector_base = '0;
    logic              first_pair  = 1'b0;
    action_t           after_busy  = ACT_NONE;
    cfg_t              opcodes     = '{RST_OP_READ, RST_OP_WRITE_ENABLE, RST_OP_WRITE_DISABLE,
                                       RST_OP_SECTOR_ERASE, RST_OP_AAI_PROGRAM,
                                       RST_OP_READ_STATUS};
    sfcs_out_t         held_byte;
    logic              have_held = 1'b0;

    spi_flash_command_sequencer_top i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Hold back the newest byte so that the final one of a request gets last
    function automatic void push_byte(logic [BYTE_W-1:0] b, logic v, logic fs, logic fe,
                                      logic cap, logic err);
        if (have_held) begin
            expected_bytes.push_back(held_byte);
        end
        held_byte = '{b, v, fs, fe, cap, err, 1'b0};
        have_held = 1'b1;
    endfunction

    function automatic void push_address(logic [ADDR_W-1:0] a, logic end_frame);
        push_byte(a[23:16], 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        push_byte(a[15:8], 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        push_byte(a[7:0], 1'b1, 1'b0, end_frame, 1'b0, 1'b0);
    endfunction

    function automatic void push_poll();
        push_byte(opcodes.op_read_status, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
        push_byte(DUMMY_BYTE, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0);
    endfunction

    // Work out the frame bytes of one accepted request and advance the phase
    function automatic void plan_frames(sfcs_in_t req);
        logic [ADDR_W-1:0] addr;
        addr = req.address & ADDR_MASK;
        if (req.mode == MODE_READ_OPEN && flash_phase == PH_IDLE) begin
            push_byte(opcodes.op_write_disable, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
            push_byte(opcodes.op_read, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
            push_address(addr, 1'b0);
            flash_phase = PH_READING;
        end else if (req.mode == MODE_READ_BYTE && flash_phase == PH_READING) begin
            push_byte(DUMMY_BYTE, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
        end else if (req.mode == MODE_READ_CLOSE && flash_phase == PH_READING) begin
            push_byte('0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
            flash_phase = PH_IDLE;
        end else if (req.mode == MODE_WRITE_OPEN && flash_phase == PH_IDLE) begin
            sector_base = addr & ~SECTOR_MASK;
            push_byte(opcodes.op_write_enable, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
            push_byte(opcodes.op_sector_erase, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
            push_address(sector_base, 1'b1);
            push_poll();
            first_pair  = 1'b1;
            after_busy  = ACT_ERASED;
            flash_phase = PH_BUSY;
        end else if (req.mode == MODE_WRITE_PAIR && flash_phase == PH_WRITING) begin
            push_byte(opcodes.op_aai_program, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
            if (first_pair) begin
                push_address(sector_base, 1'b0);
            end
            push_byte(req.data_first, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
            push_byte(req.data_second, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
            push_poll();
            first_pair  = 1'b0;
            after_busy  = ACT_PAIRED;
            flash_phase = PH_BUSY;
        end else if (req.mode == MODE_WRITE_CLOSE && flash_phase == PH_WRITING) begin
            push_byte(opcodes.op_write_disable, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
            first_pair  = 1'b0;
            flash_phase = PH_IDLE;
        end else if (req.mode == MODE_STATUS && flash_phase == PH_BUSY) begin
            if (req.status_byte[BUSY_BIT]) begin
                push_poll();
            end else begin
                if (after_busy == ACT_ERASED) begin
                    push_byte(opcodes.op_write_enable, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
                end else begin
                    push_byte('0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
                end
                after_busy  = ACT_NONE;
                flash_phase = PH_WRITING;
            end
        end else begin
            push_byte('0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
        end
        held_byte.last = 1'b1;
        expected_bytes.push_back(held_byte);
        have_held = 1'b0;
    endfunction

    function automatic void note_mismatch(string field, logic [BYTE_W-1:0] want,
                                          logic [BYTE_W-1:0] got);
        failures++;
        if (failures <= MAX_REPORTS) begin
            $display("%0t: %s mismatch: expected %02h, got %02h", $time, field, want, got);
        end
    endfunction

    // Compare one result byte with the oldest expected one
    function automatic void check_byte(sfcs_out_t got);
        sfcs_out_t want;
        if (expected_bytes.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS) begin
                $display("%0t: unexpected result: expected none, got %h", $time, got);
            end
            return;
        end
        want = expected_bytes.pop_front();
        if (got.tx_byte !== want.tx_byte)
            note_mismatch("tx_byte", want.tx_byte, got.tx_byte);
        if (got.tx_valid !== want.tx_valid)
            note_mismatch("tx_valid", BYTE_W'(want.tx_valid), BYTE_W'(got.tx_valid));
        if (got.frame_start !== want.frame_start)
            note_mismatch("frame_start", BYTE_W'(want.frame_start),
                          BYTE_W'(got.frame_start));
        if (got.frame_end !== want.frame_end)
            note_mismatch("frame_end", BYTE_W'(want.frame_end), BYTE_W'(got.frame_end));
        if (got.capture_rx !== want.capture_rx)
            note_mismatch("capture_rx", BYTE_W'(want.capture_rx),
                          BYTE_W'(got.capture_rx));
        if (got.error !== want.error)
            note_mismatch("error", BYTE_W'(want.error), BYTE_W'(got.error));
        if (got.last !== want.last)
            note_mismatch("last", BYTE_W'(want.last), BYTE_W'(got.last));
    endfunction

    // Sample both handshakes: predict on each request taken, check each result
    always @(posedge aclk) begin
        if (!aresetn) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= s_valid && s_ready;
            if (s_valid && s_ready)
                plan_frames(s_data);
            if (m_valid && m_ready)
                check_byte(m_data);
        end
    end

    // Drive requests from the pending queue; hold each until it is taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !req_taken) begin
            // hold the current request
        end else if (pending_reqs.size() != 0 &&
                     $urandom_range(99) >= send_idle_pct) begin
            next_req = pending_reqs.pop_front();
            s_data  <= next_req;
            s_valid <= 1'b1;
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Stall the result channel at random
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Write one opcode register: setup cycle, then access cycle
    task automatic write_opcode(logic [REG_IDX_W-1:0] idx, logic [BYTE_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(APB_DATA_W-BYTE_W){1'b0}}, value};
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_OP_READ:          opcodes.op_read          = value;
            REG_OP_WRITE_ENABLE:  opcodes.op_write_enable  = value;
            REG_OP_WRITE_DISABLE: opcodes.op_write_disable = value;
            REG_OP_SECTOR_ERASE:  opcodes.op_sector_erase  = value;
            REG_OP_AAI_PROGRAM:   opcodes.op_aai_program   = value;
            REG_OP_READ_STATUS:   opcodes.op_read_status   = value;
            default: ;
        endcase
    endtask

    task automatic load_opcodes(logic [BYTE_W-1:0] rd, logic [BYTE_W-1:0] we,
                                logic [BYTE_W-1:0] wd, logic [BYTE_W-1:0] se,
                                logic [BYTE_W-1:0] aai, logic [BYTE_W-1:0] rs);
        write_opcode(REG_OP_READ, rd);
        write_opcode(REG_OP_WRITE_ENABLE, we);
        write_opcode(REG_OP_WRITE_DISABLE, wd);
        write_opcode(REG_OP_SECTOR_ERASE, se);
        write_opcode(REG_OP_AAI_PROGRAM, aai);
        write_opcode(REG_OP_READ_STATUS, rs);
    endtask

    // Wait until every request is taken and every byte has come out
    task automatic settle();
        while (pending_reqs.size() != 0 || s_valid || expected_bytes.size() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic post(logic [2:0] mode, logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] d1,
                        logic [BYTE_W-1:0] d2, logic [BYTE_W-1:0] st);
        sfcs_in_t req;
        req.mode        = mode;
        req.address     = addr;
        req.data_first  = d1;
        req.data_second = d2;
        req.status_byte = st;
        pending_reqs.push_back(req);
        reqs_queued++;
    endtask

    task automatic post_random(logic [2:0] mode);
        post(mode, ADDR_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
             BYTE_W'($urandom));
    endtask

    task automatic post_status(logic busy);
        logic [BYTE_W-1:0] st;
        st           = BYTE_W'($urandom);
        st[BUSY_BIT] = busy;
        post(MODE_STATUS, ADDR_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom), st);
    endtask

    function automatic logic mode_fits(phase_t ph, logic [2:0] m);
        case (ph)
            PH_IDLE:    return m == MODE_READ_OPEN || m == MODE_WRITE_OPEN;
            PH_READING: return m == MODE_READ_BYTE || m == MODE_READ_CLOSE;
            PH_BUSY:    return m == MODE_STATUS;
            default:    return m == MODE_WRITE_PAIR || m == MODE_WRITE_CLOSE;
        endcase
    endfunction

    // Drop in a request that is out of phase now and so leaves the phase alone
    task automatic stray(phase_t ph, logic always_send);
        logic [2:0] m;
        if (always_send || $urandom_range(99) < 12) begin
            m = 3'($urandom_range(7));
            while (mode_fits(ph, m))
                m = 3'($urandom_range(7));
            post_random(m);
        end
    endtask

    // Busy replies, then the one that clears busy
    task automatic post_poll_replies();
        int busy_count;
        busy_count = $urandom_range(2);
        repeat (busy_count) post_status(1'b1);
        post_status(1'b0);
    endtask

    // Mostly well-formed sessions with random content, some stray requests
    task automatic queue_sessions(int target);
        int pick;
        int count;
        while (reqs_queued < target) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                post_random(MODE_WRITE_OPEN);
                stray(PH_BUSY, 1'b0);
                post_poll_replies();
                stray(PH_WRITING, 1'b0);
                count = $urandom_range(4);
                repeat (count) begin
                    post_random(MODE_WRITE_PAIR);
                    stray(PH_BUSY, 1'b0);
                    post_poll_replies();
                    stray(PH_WRITING, 1'b0);
                end
                post_random(MODE_WRITE_CLOSE);
            end else if (pick < 80) begin
                post_random(MODE_READ_OPEN);
                stray(PH_READING, 1'b0);
                count = $urandom_range(6);
                repeat (count) begin
                    post_random(MODE_READ_BYTE);
                    stray(PH_READING, 1'b0);
                end
                post_random(MODE_READ_CLOSE);
            end else begin
                stray(PH_IDLE, 1'b1);
            end
        end
    endtask

    // Reset, directed requests, then three random phases
    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // Reset opcodes; extremes of every field and each special case
        post(MODE_READ_BYTE, 24'h000000, 8'h00, 8'h00, 8'h00);    // wrong phase
        post(MODE_UNDEFINED, 24'hFFFFFF, 8'hFF, 8'hFF, 8'hFF);    // undefined mode
        post(MODE_READ_OPEN, 24'hFFFFFF, 8'h00, 8'h00, 8'h00);
        post(MODE_READ_BYTE, 24'h000000, 8'hFF, 8'hFF, 8'hFF);
        post(MODE_READ_BYTE, 24'h123456, 8'h00, 8'h00, 8'h00);
        post(MODE_WRITE_OPEN, 24'hABCDEF, 8'h00, 8'h00, 8'h00);   // wrong phase
        post(MODE_READ_CLOSE, 24'hFFFFFF, 8'hFF, 8'hFF, 8'hFF);
        post(MODE_READ_OPEN, 24'h000000, 8'hFF, 8'hFF, 8'hFF);
        post(MODE_READ_CLOSE, 24'h000000, 8'h00, 8'h00, 8'h00);
        post(MODE_WRITE_OPEN, 24'hFFFFFF, 8'hFF, 8'hFF, 8'hFF);
        post(MODE_STATUS, 24'h000000, 8'h00, 8'h00, 8'hFF);       // still busy
        post(MODE_WRITE_PAIR, 24'h000000, 8'h11, 8'h22, 8'h00);   // wrong phase
        post(MODE_STATUS, 24'h000000, 8'h00, 8'h00, 8'hFE);       // erase done
        post(MODE_WRITE_PAIR, 24'h000000, 8'hFF, 8'h00, 8'h00);   // carries address
        post(MODE_STATUS, 24'hFFFFFF, 8'h00, 8'h00, 8'h00);       // pair done
        post(MODE_WRITE_PAIR, 24'hFFFFFF, 8'h00, 8'hFF, 8'hFF);   // no address
        post(MODE_STATUS, 24'h000000, 8'h00, 8'h00, 8'h01);
        post(MODE_STATUS, 24'h000000, 8'h00, 8'h00, 8'hFE);
        post(MODE_READ_OPEN, 24'h000000, 8'h00, 8'h00, 8'h00);    // wrong phase
        post(MODE_WRITE_CLOSE, 24'h000000, 8'h00, 8'h00, 8'h00);
        post(MODE_WRITE_CLOSE, 24'h000000, 8'h00, 8'h00, 8'h00);  // wrong phase
        post(MODE_STATUS, 24'h000000, 8'h00, 8'h00, 8'h00);       // wrong phase
        post(MODE_WRITE_OPEN, 24'h000FFF, 8'h00, 8'h00, 8'h00);   // aligns to zero
        post(MODE_STATUS, 24'h000000, 8'h00, 8'h00, 8'h00);
        post(MODE_WRITE_CLOSE, 24'hFFFFFF, 8'hFF, 8'hFF, 8'hFF);
        settle();

        // Slow receiver, random opcodes
        load_opcodes(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                     BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
        queue_sessions(90);
        settle();

        // Slow sender, extreme opcodes
        send_idle_pct  = 79;
        recv_stall_pct = 22;
        load_opcodes(8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF);
        queue_sessions(155);
        settle();

        // Full rate both ways, the other extremes
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        load_opcodes(8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00);
        queue_sessions(220);
        settle();

        if (failures == 0) begin
            $display("spi_flash_command_sequencer_top regression: pass");
        end else begin
            $display("spi_flash_command_sequencer_top regression: fail");
        end
        $finish;
    end

    // Abandon a hung run
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("spi_flash_command_sequencer_top regression: fail");
        $finish;
    end

endmodule

### filelist.f
rtl/sfcs_pkg.sv
rtl/sfcs_front.sv
rtl/sfcs_queue.sv
rtl/sfcs_back.sv
rtl/spi_flash_command_sequencer_top.sv
tb/sv/tb_spi_flash_command_sequencer_top.sv
